[rtl/ppsa_pkg.sv]
// Shared constants, codes and controller/datapath link types for the slot allocator.
// No dependencies; the top level, controller, datapath and checker import it.
package ppsa_pkg;

	// default sizing, handed down from the top level
	localparam int MAX_PAGES_DEF          = 16;
	localparam int MAX_SLOTS_PER_PAGE_DEF = 256;
	localparam int MAX_SLOT_BYTES_DEF     = 4096;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int ADDR_W = 24;
	localparam int STAT_W = 2;
	localparam int PIU_W  = 5;
	localparam int CNT_W  = 13;
	localparam int SZ_W   = 13;
	localparam int OPP_W  = 9;
	localparam int CFG_W  = 13;
	localparam int CFGI_W = 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
	localparam logic [SZ_W-1:0]  LINK_SIZE = 13'd8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOP    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTOWN = 2'd2;

	// register indexes and reset values
	localparam logic [CFGI_W-1:0] REG_OBJECT_SIZE      = 1'd0;
	localparam logic [CFGI_W-1:0] REG_OBJECTS_PER_PAGE = 1'd1;
	localparam logic [SZ_W-1:0]   OBJECT_SIZE_RST      = 13'd8;
	localparam logic [OPP_W-1:0]  OBJECTS_PER_PAGE_RST = 9'd16;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic list_clear;
		logic fill_start;
		logic fill_step;
		logic pop;
		logic free_commit;
		logic release_all;
		logic set_oop;
		logic set_notown;
		logic out_load;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             list_empty;
		logic             pages_full;
		logic             fill_last;
		logic             div_busy;
		logic             free_ok;
		logic             out_busy;
	} dp_stat_t;

endpackage

[rtl/paged_pool_slot_allocator_unit.sv]
// Allocate from the list: decode, list check, link read of the head, pop, result word;
// a page claim first writes one link per object of the page. Free runs the 24-step
// divider for the ownership check; release-all and unknown commands skip to the result.
// Throughput: one word in flight; the next is taken once the result enters the output
// register. Reset: asynchronous, clears list, page count and registers to defaults.
module paged_pool_slot_allocator_unit #(
	parameter int MAX_PAGES          = ppsa_pkg::MAX_PAGES_DEF,
	parameter int MAX_SLOTS_PER_PAGE = ppsa_pkg::MAX_SLOTS_PER_PAGE_DEF,
	parameter int MAX_SLOT_BYTES     = ppsa_pkg::MAX_SLOT_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ppsa_pkg::CFGI_W-1:0] cfg_index,
	input  logic [ppsa_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ppsa_pkg::CMD_W-1:0]  cmd,
	input  logic [ppsa_pkg::ADDR_W-1:0] slot_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ppsa_pkg::ADDR_W-1:0] granted_address,
	output logic [ppsa_pkg::STAT_W-1:0] status,
	output logic [ppsa_pkg::PIU_W-1:0]  pages_in_use,
	output logic [ppsa_pkg::CNT_W-1:0]  free_slots
);
	import ppsa_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequencer
	ppsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// list, arithmetic and result word
	ppsa_dp #(
		.MAX_PAGES          (MAX_PAGES),
		.MAX_SLOTS_PER_PAGE (MAX_SLOTS_PER_PAGE),
		.MAX_SLOT_BYTES     (MAX_SLOT_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.slot_address    (slot_address),
		.ctl             (ctl),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted_address (granted_address),
		.status          (status),
		.pages_in_use    (pages_in_use),
		.free_slots      (free_slots)
	);

endmodule

[rtl/ppsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ppsa_div.sv]
// Restoring divider, one quotient bit a cycle, for the ownership check.
// No dependencies.
module ppsa_div #(
	parameter int DVD_W = 24,
	parameter int DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W+1:0]  trial;

	// shift in the next dividend bit and try the subtraction
	assign shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DVS_W+1]) begin
				rem_q <= trial[DVS_W:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DVS_W-1:0];

endmodule

[rtl/ppsa_ctrl.sv]
// Sequencing state machine of the slot allocator: one command at a time.
// Depends on ppsa_pkg.
module ppsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppsa_pkg::dp_stat_t stat,
	output ppsa_pkg::dp_ctl_t  ctl
);
	import ppsa_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_ALLOC  = 4'd2;
	localparam logic [3:0] S_FILL   = 4'd3;
	localparam logic [3:0] S_POP    = 4'd4;
	localparam logic [3:0] S_POPW   = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_FREE   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_ALLOC: state_d = S_ALLOC;
					CMD_FREE: begin
						ctl.div_start = 1'b1;
						state_d       = S_DIV;
					end
					CMD_RELEASE: begin
						ctl.release_all = 1'b1;
						state_d         = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ALLOC: begin
				if (stat.list_empty) begin
					ctl.list_clear = 1'b1;
					if (stat.pages_full) begin
						ctl.set_oop = 1'b1;
						state_d     = S_DONE;
					end else begin
						ctl.fill_start = 1'b1;
						state_d        = S_FILL;
					end
				end else begin
					state_d = S_POP;
				end
			end
			S_FILL: begin
				ctl.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_d = S_POP;
				end
			end
			// link memory read of the head is in flight
			S_POP: state_d = S_POPW;
			S_POPW: begin
				ctl.pop = 1'b1;
				state_d = S_DONE;
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_FREE;
				end
			end
			S_FREE: begin
				if (stat.free_ok) begin
					ctl.free_commit = 1'b1;
				end else begin
					ctl.set_notown = 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/ppsa_dp.sv]
// Datapath of the slot allocator: registers, free list, multipliers, divider, result word.
// Depends on ppsa_pkg, ppsa_ram and ppsa_div.
module ppsa_dp #(
	parameter int MAX_PAGES          = ppsa_pkg::MAX_PAGES_DEF,
	parameter int MAX_SLOTS_PER_PAGE = ppsa_pkg::MAX_SLOTS_PER_PAGE_DEF,
	parameter int MAX_SLOT_BYTES     = ppsa_pkg::MAX_SLOT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppsa_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [ppsa_pkg::CFG_W-1:0]    cfg_data,
	input  logic [ppsa_pkg::CMD_W-1:0]    cmd,
	input  logic [ppsa_pkg::ADDR_W-1:0]   slot_address,
	input  ppsa_pkg::dp_ctl_t             ctl,
	output ppsa_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ppsa_pkg::ADDR_W-1:0]   granted_address,
	output logic [ppsa_pkg::STAT_W-1:0]   status,
	output logic [ppsa_pkg::PIU_W-1:0]    pages_in_use,
	output logic [ppsa_pkg::CNT_W-1:0]    free_slots
);
	import ppsa_pkg::*;

	localparam int TOTAL  = MAX_PAGES * MAX_SLOTS_PER_PAGE;
	localparam int IDX_W  = $clog2(TOTAL + 1);
	localparam int RAM_AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int PG_W   = $clog2(MAX_PAGES + 1);
	localparam int BASE_W = PG_W + OPP_W;
	localparam int LIM_W  = BASE_W + SZ_W;
	localparam int PROD_W = IDX_W + SZ_W;
	localparam int CMP_W  = LIM_W + ADDR_W;
	localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(TOTAL);

	logic [SZ_W-1:0]   osz_raw_q;
	logic [OPP_W-1:0]  opp_raw_q;
	logic [SZ_W-1:0]   osz;
	logic [OPP_W-1:0]  opp;
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [PG_W-1:0]   page_q;
	logic [OPP_W-1:0]  fill_q;
	logic [BASE_W-1:0] base_q;
	logic [LIM_W-1:0]  limit_q;
	logic [ADDR_W-1:0] granted_q;
	logic [STAT_W-1:0] status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [PIU_W-1:0]  out_pages_q;
	logic [CNT_W-1:0]  out_free_q;
	logic [IDX_W-1:0]  fill_idx;
	logic [IDX_W-1:0]  fill_prev;
	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] quo;
	logic [SZ_W-1:0]   rem;
	logic              div_busy;
	logic [IDX_W-1:0]  free_idx;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_rdata;

	// clamp the configured sizes
	always_comb begin
		osz = osz_raw_q;
		if (osz_raw_q < LINK_SIZE) begin
			osz = LINK_SIZE;
		end else if (int'(osz_raw_q) > MAX_SLOT_BYTES) begin
			osz = SZ_W'(MAX_SLOT_BYTES);
		end
		opp = opp_raw_q;
		if (opp_raw_q == '0) begin
			opp = OPP_W'(1);
		end else if (int'(opp_raw_q) > MAX_SLOTS_PER_PAGE) begin
			opp = OPP_W'(MAX_SLOTS_PER_PAGE);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osz_raw_q <= OBJECT_SIZE_RST;
			opp_raw_q <= OBJECTS_PER_PAGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OBJECT_SIZE:      osz_raw_q <= cfg_data[SZ_W-1:0];
				REG_OBJECTS_PER_PAGE: opp_raw_q <= cfg_data[OPP_W-1:0];
				default: ;
			endcase
		end
	end

	// page base and owned limit, one multiply per register
	always_ff @(posedge clk) begin
		base_q  <= BASE_W'(page_q) * BASE_W'(opp);
		limit_q <= LIM_W'(base_q) * LIM_W'(osz);
	end

	assign fill_idx  = IDX_W'(base_q + BASE_W'(fill_q));
	assign fill_prev = IDX_W'(base_q + BASE_W'(fill_q) - 1'b1);
	assign prod      = PROD_W'(head_q) * PROD_W'(osz);
	assign free_idx  = IDX_W'(quo);

	ppsa_div #(
		.DVD_W (ADDR_W),
		.DVS_W (SZ_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (addr_q),
		.divisor   (osz),
		.busy      (div_busy),
		.quotient  (quo),
		.remainder (rem)
	);

	// link memory write: page claim or freed slot
	always_comb begin
		ram_we    = ctl.fill_step | ctl.free_commit;
		ram_waddr = free_idx;
		ram_wdata = (count_q == '0) ? NULL_IDX : head_q;
		if (ctl.fill_step) begin
			ram_waddr = fill_idx;
			ram_wdata = (fill_q == '0) ? NULL_IDX : fill_prev;
		end
	end

	ppsa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (TOTAL)
	) u_link (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr[RAM_AW-1:0]),
		.wdata (ram_wdata),
		.raddr (head_q[RAM_AW-1:0]),
		.rdata (ram_rdata)
	);

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_IDX;
			count_q <= '0;
			page_q  <= '0;
			fill_q  <= '0;
			cmd_q   <= CMD_ALLOC;
		end else begin
			if (ctl.load) begin
				cmd_q <= cmd;
			end
			if (ctl.list_clear || ctl.release_all) begin
				head_q  <= NULL_IDX;
				count_q <= '0;
			end
			if (ctl.release_all) begin
				page_q <= '0;
			end
			if (ctl.fill_start) begin
				fill_q <= '0;
			end
			if (ctl.fill_step) begin
				head_q  <= fill_idx;
				count_q <= CNT_W'(fill_q) + 1'b1;
				fill_q  <= fill_q + 1'b1;
				if (stat.fill_last) begin
					page_q <= page_q + 1'b1;
				end
			end
			if (ctl.pop) begin
				count_q <= count_q - 1'b1;
				head_q  <= (count_q == CNT_W'(1)) ? NULL_IDX : ram_rdata;
			end
			if (ctl.free_commit) begin
				head_q <= free_idx;
				if (count_q < COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// per-command payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			addr_q    <= slot_address;
			granted_q <= '0;
			status_q  <= ST_OK;
		end
		if (ctl.pop) begin
			granted_q <= ADDR_W'(prod);
		end
		if (ctl.set_oop) begin
			status_q <= ST_OOP;
		end
		if (ctl.set_notown) begin
			status_q <= ST_NOTOWN;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_addr_q  <= granted_q;
			out_stat_q  <= status_q;
			out_pages_q <= PIU_W'(page_q);
			out_free_q  <= count_q;
		end
	end

	assign stat.cmd        = cmd_q;
	assign stat.list_empty = (count_q == '0) || (head_q >= NULL_IDX);
	assign stat.pages_full = (int'(page_q) >= MAX_PAGES);
	assign stat.fill_last  = (fill_q == opp - 1'b1);
	assign stat.div_busy   = div_busy;
	assign stat.free_ok    = (CMP_W'(addr_q) < CMP_W'(limit_q)) && (rem == '0);
	assign stat.out_busy   = out_valid_q & ~out_ready;

	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status          = out_stat_q;
	assign pages_in_use    = out_pages_q;
	assign free_slots      = out_free_q;

endmodule

[rtl/ppsa_checker.sv]
// Port-level checks on the slot allocator, bound to the top level.
// Depends on ppsa_pkg and paged_pool_slot_allocator_unit.
module ppsa_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ppsa_pkg::ADDR_W-1:0] granted_address,
	input logic [ppsa_pkg::STAT_W-1:0] status,
	input logic [ppsa_pkg::PIU_W-1:0]  pages_in_use
);
	import ppsa_pkg::*;

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_address) && $stable(status))
		else $error("result word changed while stalled");

	// one command in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	// failures grant nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OOP || status == ST_NOTOWN) |-> granted_address == '0)
		else $error("address granted on failure");

	// out of pages only when every page is claimed
	a_oop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OOP |-> pages_in_use == PIU_W'(MAX_PAGES_DEF))
		else $error("out of pages below the page limit");

endmodule

bind paged_pool_slot_allocator_unit ppsa_props u_ppsa_checker (.*);
